FILE: sv/fcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types, constants and the CRC-16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int unsigned DEF_NUM_TARGETS  = 8;
   localparam int unsigned DEF_NUM_COMMANDS = 16;

   localparam logic [7:0]  START_CODE_A = 8'h55;
   localparam logic [7:0]  START_CODE_B = 8'hAA;
   localparam logic [15:0] CRC_SEED     = 16'h1D0F;
   localparam logic [15:0] CRC_POLY     = 16'hA02B;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned POS_W        = 17;

   // header byte index
   localparam logic [2:0] HDR_START_LO = 3'd0;
   localparam logic [2:0] HDR_START_HI = 3'd1;
   localparam logic [2:0] HDR_LEN_LO   = 3'd2;
   localparam logic [2:0] HDR_LEN_HI   = 3'd3;
   localparam logic [2:0] HDR_CRC_LO   = 3'd4;
   localparam logic [2:0] HDR_CRC_HI   = 3'd5;
   localparam logic [2:0] HDR_TARGET   = 3'd6;
   localparam logic [2:0] HDR_COMMAND  = 3'd7;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_START = 2'd1,
      ST_BAD_CRC   = 2'd2,
      ST_BAD_ROUTE = 2'd3
   } status_type;

   typedef struct packed {
      logic feed;
      logic restart;
   } crc_ctrl_type;

   // MSB-first CRC-16, one byte, unrolled
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: sv/fcr_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_crc16
// Running CRC-16 over payload bytes; one byte per cycle while feed is set, restart to the seed.
// ----------------------------------------------------------------------------
module fcr_crc16 import fcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   input  logic [7:0]   data,
   output logic [15:0]  crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      priority if (ctrl.restart) begin
         crc_in = CRC_SEED;
      end else if (ctrl.feed) begin
         crc_in = crc16_byte(crc_ff, data);
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_SEED;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

FILE: sv/frame_check_and_route.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_check_and_route
// Checked frame deframer: forwards payload bytes and closes each frame with a
// status transfer (start code, CRC-16, then target/command bounds).
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and has one result register, so a byte
// can be accepted in every cycle while the result side keeps up. The
// per-byte work is an eight-bit unrolled CRC-16 update and a 17-bit position
// compare. Header bytes give no data transfer; each payload byte is
// forwarded as it arrives. For a zero-length frame the status comes with the
// command byte; otherwise it comes with the byte after the last payload
// byte, which is taken as the first header byte of the next frame. A bad
// start code does not resynchronise: the header length is still used.
// ----------------------------------------------------------------------------
module frame_check_and_route import fcr_pkg::*; #(
   parameter int unsigned NUM_TARGETS  = DEF_NUM_TARGETS,
   parameter int unsigned NUM_COMMANDS = DEF_NUM_COMMANDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_frame_target,
   output logic [7:0]  rsp_frame_command,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last
);

   localparam logic [8:0] TARGET_LIMIT  = 9'(NUM_TARGETS);
   localparam logic [8:0] COMMAND_LIMIT = 9'(NUM_COMMANDS);

   function automatic status_type frame_status(
      input logic [15:0] sc, input logic [15:0] rx_crc, input logic [15:0] run_crc,
      input logic [7:0] tgt, input logic [7:0] cmd);
      status_type st;
      priority if (sc != {START_CODE_B, START_CODE_A}) begin
         st = ST_BAD_START;
      end else if (rx_crc != run_crc) begin
         st = ST_BAD_CRC;
      end else if ({1'b0, tgt} >= TARGET_LIMIT || {1'b0, cmd} >= COMMAND_LIMIT) begin
         st = ST_BAD_ROUTE;
      end else begin
         st = ST_OK;
      end
      return st;
   endfunction

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      start_ff, start_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      rx_crc_ff, rx_crc_in;
   logic [7:0]       target_ff, target_in;
   logic [7:0]       command_ff, command_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_data_ff, out_data_in;
   status_type  out_status_ff, out_status_in;
   logic [7:0]  out_target_ff, out_target_in;
   logic [7:0]  out_command_ff, out_command_in;
   logic [15:0] out_length_ff, out_length_in;

   logic             accept;
   logic             pending;
   logic [POS_W-1:0] pos_eff;
   logic             res_valid;
   crc_ctrl_type     crc_ctrl;
   logic [15:0]      run_crc;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   fcr_crc16 u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .data  (req_rx_byte),
      .crc   (run_crc)
   );

   always_comb begin
      pending    = pos_ff >= (POS_W'(len_ff) + POS_W'(HEADER_BYTES));
      pos_eff    = pending ? '0 : pos_ff;
      pos_in     = pos_eff + POS_W'(1);
      start_in   = start_ff;
      len_in     = len_ff;
      rx_crc_in  = rx_crc_ff;
      target_in  = target_ff;
      command_in = command_ff;
      crc_ctrl   = '{feed: 1'b0, restart: pending};

      res_valid      = 1'b0;
      out_kind_in    = KIND_DATA;
      out_data_in    = 8'h00;
      out_status_in  = ST_OK;
      out_target_in  = target_ff;
      out_command_in = command_ff;
      out_length_in  = len_ff;

      if (pending) begin
         res_valid     = 1'b1;
         out_kind_in   = KIND_STATUS;
         out_status_in = frame_status(start_ff, rx_crc_ff, run_crc, target_ff, command_ff);
      end

      if (pos_eff < POS_W'(HEADER_BYTES)) begin
         unique case (pos_eff[2:0])
            HDR_START_LO: start_in   = {start_ff[15:8], req_rx_byte};
            HDR_START_HI: start_in   = {req_rx_byte, start_ff[7:0]};
            HDR_LEN_LO:   len_in     = {len_ff[15:8], req_rx_byte};
            HDR_LEN_HI:   len_in     = {req_rx_byte, len_ff[7:0]};
            HDR_CRC_LO:   rx_crc_in  = {rx_crc_ff[15:8], req_rx_byte};
            HDR_CRC_HI:   rx_crc_in  = {req_rx_byte, rx_crc_ff[7:0]};
            HDR_TARGET:   target_in  = req_rx_byte;
            HDR_COMMAND:  command_in = req_rx_byte;
            default:      command_in = req_rx_byte;
         endcase
         if (pos_eff[2:0] == HDR_COMMAND && len_in == 16'h0000) begin
            // zero-length frame closes with the command byte; CRC is at seed
            res_valid        = 1'b1;
            out_kind_in      = KIND_STATUS;
            out_status_in    = frame_status(start_in, rx_crc_in, CRC_SEED, target_in,
                                            command_in);
            out_target_in    = target_in;
            out_command_in   = command_in;
            out_length_in    = len_in;
            crc_ctrl.restart = 1'b1;
            pos_in           = '0;
         end
      end else begin
         crc_ctrl.feed = 1'b1;
         res_valid     = 1'b1;
         out_kind_in   = KIND_DATA;
         out_data_in   = req_rx_byte;
         out_status_in = ST_OK;
      end

      if (!accept) begin
         crc_ctrl = '{feed: 1'b0, restart: 1'b0};
      end

      if (accept) begin
         out_valid_in = res_valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         start_ff     <= '0;
         len_ff       <= '0;
         rx_crc_ff    <= '0;
         target_ff    <= '0;
         command_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            pos_ff     <= pos_in;
            start_ff   <= start_in;
            len_ff     <= len_in;
            rx_crc_ff  <= rx_crc_in;
            target_ff  <= target_in;
            command_ff <= command_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         out_kind_ff    <= out_kind_in;
         out_data_ff    <= out_data_in;
         out_status_ff  <= out_status_in;
         out_target_ff  <= out_target_in;
         out_command_ff <= out_command_in;
         out_length_ff  <= out_length_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_frame_target  = out_target_ff;
   assign rsp_frame_command = out_command_ff;
   assign rsp_frame_length  = out_length_ff;
   assign rsp_last          = out_kind_ff;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_check_and_route. Byte frames are built with
// their header CRC and fed through the request channel. Every accepted byte
// goes through a local deframer that predicts the forwarded payload bytes and
// the closing status transfers. Result transfers are checked in order, field
// by field. The run moves through phases of sender idling and receiver
// stalling and includes at least one frame whose length needs the high length byte.
// ----------------------------------------------------------------------------
module testbench;
   import fcr_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam int unsigned PHASE_BYTES = 55;
   localparam int unsigned SEND_IDLE  [4] = '{0, 64, 0, 32};
   localparam int unsigned RECV_STALL [4] = '{0, 0, 64, 32};

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      status_type  status;
      logic [7:0]  target;
      logic [7:0]  command;
      logic [15:0] length;
      logic        last;
   } deframed_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_frame_target;
   logic [7:0]  rsp_frame_command;
   logic [15:0] rsp_frame_length;
   logic        rsp_last;

   logic [7:0]   rx_stream[$];
   deframed_type due_transfers[$];
   int unsigned  bytes_queued   = 0;
   int unsigned  bytes_taken    = 0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  fault_count    = 0;
   int unsigned  quiet_cycles   = 0;

   // deframer state
   logic [16:0] pos_m      = '0;
   logic [15:0] starts_m   = '0;
   logic [15:0] len_m      = '0;
   logic [15:0] hdr_crc_m  = '0;
   logic [15:0] crc_m      = CRC_SEED;
   logic [7:0]  tgt_m      = '0;
   logic [7:0]  cmd_m      = '0;

   frame_check_and_route #(
      .NUM_TARGETS  (DEF_NUM_TARGETS),
      .NUM_COMMANDS (DEF_NUM_COMMANDS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_status        (rsp_status),
      .rsp_frame_target  (rsp_frame_target),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bit-serial form of the MSB-first CRC-16
   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb)
            c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic status_type judge_frame();
      if (starts_m != {START_CODE_B, START_CODE_A})
         return ST_BAD_START;
      if (hdr_crc_m != crc_m)
         return ST_BAD_CRC;
      if (tgt_m >= DEF_NUM_TARGETS || cmd_m >= DEF_NUM_COMMANDS)
         return ST_BAD_ROUTE;
      return ST_OK;
   endfunction

   task automatic close_frame();
      due_transfers.push_back('{kind: KIND_STATUS, data: 8'h00, status: judge_frame(),
                                target: tgt_m, command: cmd_m, length: len_m,
                                last: 1'b1});
      crc_m = CRC_SEED;
      pos_m = '0;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      if (pos_m >= HEADER_BYTES + len_m)
         close_frame();
      if (pos_m < HEADER_BYTES) begin
         case (pos_m[2:0])
            HDR_START_LO: starts_m[7:0]   = b;
            HDR_START_HI: starts_m[15:8]  = b;
            HDR_LEN_LO:   len_m[7:0]      = b;
            HDR_LEN_HI:   len_m[15:8]     = b;
            HDR_CRC_LO:   hdr_crc_m[7:0]  = b;
            HDR_CRC_HI:   hdr_crc_m[15:8] = b;
            HDR_TARGET:   tgt_m           = b;
            default:      cmd_m           = b;
         endcase
         pos_m = pos_m + 1'b1;
         if (pos_m == HEADER_BYTES && len_m == 16'd0)
            close_frame();
      end else begin
         crc_m = crc_step(crc_m, b);
         pos_m = pos_m + 1'b1;
         due_transfers.push_back('{kind: KIND_DATA, data: b, status: ST_OK,
                                   target: tgt_m, command: cmd_m, length: len_m,
                                   last: 1'b0});
      end
   endtask

   // first two payload bytes given, the rest random
   task automatic queue_frame(input logic [7:0] start_a, start_b, input logic [15:0] len,
                              input bit crc_good, input logic [7:0] tgt, cmd,
                              input logic [7:0] p0, p1);
      logic [7:0]  body[$];
      logic [15:0] crc;
      logic [7:0]  b;
      crc = CRC_SEED;
      for (int k = 0; k < len; k++) begin
         b = (k == 0) ? p0 : (k == 1) ? p1 : 8'($urandom);
         body.push_back(b);
         crc = crc_step(crc, b);
      end
      if (!crc_good)
         crc = crc ^ 16'($urandom_range(1, 65535));
      rx_stream.push_back(start_a);
      rx_stream.push_back(start_b);
      rx_stream.push_back(len[7:0]);
      rx_stream.push_back(len[15:8]);
      rx_stream.push_back(crc[7:0]);
      rx_stream.push_back(crc[15:8]);
      rx_stream.push_back(tgt);
      rx_stream.push_back(cmd);
      foreach (body[i])
         rx_stream.push_back(body[i]);
      bytes_queued += HEADER_BYTES + len;
   endtask

   task automatic report_fault(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fault_count++;
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_fault($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            deframe_byte(req_rx_byte);
            bytes_taken++;
         end
         if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);

   // result monitor
   always @(posedge clock) begin
      deframed_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_transfers.size() == 0) begin
            report_fault("result transfer with none expected");
         end else begin
            want = due_transfers.pop_front();
            check_field("kind", 16'(rsp_kind), 16'(want.kind));
            check_field("data_byte", 16'(rsp_data_byte), 16'(want.data));
            check_field("status", 16'(rsp_status), 16'(want.status));
            check_field("frame_target", 16'(rsp_frame_target), 16'(want.target));
            check_field("frame_command", 16'(rsp_frame_command), 16'(want.command));
            check_field("frame_length", rsp_frame_length, want.length);
            check_field("last", 16'(rsp_last), 16'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0]  sa, sb, tgt, cmd;
      logic [15:0] len;
      int unsigned r, phase_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty frame, highest legal route
      queue_frame(START_CODE_A, START_CODE_B, 16'd0, 1'b1, 8'd7, 8'd15, 8'h00, 8'h00);
      // one byte, command out of range; status comes with the next header byte
      queue_frame(START_CODE_A, START_CODE_B, 16'd1, 1'b1, 8'd0, 8'd16, 8'hFF, 8'h00);
      // bad start code wins over bad CRC and bad target
      queue_frame(8'h00, 8'hFF, 16'd0, 1'b0, 8'd200, 8'd0, 8'h00, 8'h00);
      // bad CRC wins over bad route
      queue_frame(START_CODE_A, START_CODE_B, 16'd2, 1'b0, 8'd8, 8'd255, 8'h00, 8'h80);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = SEND_IDLE[ph];
         recv_stall_pct = RECV_STALL[ph];
         phase_start    = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) begin
            sa = START_CODE_A;
            sb = START_CODE_B;
            r  = $urandom_range(99);
            if (r < 8)
               sa = 8'($urandom);
            else if (r < 15)
               sb = 8'($urandom);
            r = $urandom_range(99);
            if (r < 20)
               len = 16'd0;
            else if (r < 80)
               len = 16'($urandom_range(1, 8));
            else if (r < 97)
               len = 16'($urandom_range(9, 40));
            else
               len = 16'($urandom_range(41, 300));
            tgt = ($urandom_range(99) < 70) ? 8'($urandom_range(0, DEF_NUM_TARGETS - 1))
                                            : 8'($urandom);
            cmd = ($urandom_range(99) < 70) ? 8'($urandom_range(0, DEF_NUM_COMMANDS - 1))
                                            : 8'($urandom);
            queue_frame(sa, sb, len, $urandom_range(99) < 80, tgt, cmd,
                        8'($urandom), 8'($urandom));
         end
         // frame with the high length byte set, run without idling
         if (ph == 0)
            queue_frame(START_CODE_A, START_CODE_B, 16'h0100, 1'b1, 8'd3, 8'd9,
                        8'($urandom), 8'($urandom));
         while (bytes_taken != bytes_queued)
            @(posedge clock);
      end

      // empty frame flushes the status of the one before and closes itself
      queue_frame(START_CODE_A, START_CODE_B, 16'd0, 1'b1, 8'd1, 8'd2, 8'h00, 8'h00);
      while (bytes_taken != bytes_queued || due_transfers.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: frame_check_and_route.f
sv/fcr_pkg.sv
sv/fcr_crc16.sv
sv/frame_check_and_route.sv
sim/testbench.sv
